>>> hdl/max_heap_priority_queue_assert.svh
// Assertion macros for the max-heap priority queue checker.
// No dependencies; included by the checker file.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MHPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mhpq assertion failed");

// Next-cycle implication, disabled during reset.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mhpq assertion failed");

`endif

>>> hdl/mhpq_pkg.sv
// Types and constants shared by the max-heap priority queue files.
// No dependencies.
package mhpq_pkg;

  localparam logic [2:0] CMD_PEEK    = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_POP     = 3'd2;
  localparam logic [2:0] CMD_REPLACE = 3'd3;
  localparam logic [2:0] CMD_DELETE  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_MISSING = 2'd3;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic signed [31:0] new_key;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         entry_count;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_LAST_RD,
    ST_LAST_GET,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

>>> hdl/max_heap_priority_queue.sv
// Binary max-heap priority queue: one command in, one result out per command.
// Depends on mhpq_pkg.
//
// The heap sits in one memory of CAPACITY entries (one read, one write per
// cycle, registered read data); every command ends by reading slot 0 for the
// maximum. Peek only reads slot 0; insert climbs a level at a time; pop
// moves the last entry to slot 0 and sifts it down; replace and delete
// first scan the entries one per cycle and then sift as above. A new
// command is taken only after the previous one has left its work state;
// the result register lets a finished result wait while the next command runs.
module max_heap_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mhpq_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mhpq_pkg::out_t out_data
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_r;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               both_r, both_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               rdv_r, rdv_nxt;
  logic [AW-1:0]      chk_r, chk_nxt;
  logic signed [31:0] lv_r, lv_nxt;
  logic               rvld_r, rvld_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] nk_r, nk_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               re, we;
  logic [AW-1:0]      ra, wa;
  logic signed [31:0] wd;
  logic [XW-1:0]      lc, rc, cnt_x;
  logic [AW-1:0]      parent;
  logic [CW-1:0]      cnt_dec;
  logic signed [31:0] best_v;
  logic [XW-1:0]      best_i;
  logic               best_is_pos;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rdv_r       <= rdv_nxt;
    end
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    both_r     <= both_nxt;
    idx_r      <= idx_nxt;
    chk_r      <= chk_nxt;
    lv_r       <= lv_nxt;
    rvld_r     <= rvld_nxt;
    stat_r     <= stat_nxt;
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    nk_r       <= nk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign lc      = {1'b0, pos_r, 1'b1};
  assign rc      = lc + XW'(1);
  assign cnt_x   = XW'(cnt_r);
  assign parent  = (pos_r - AW'(1)) >> 1;
  assign cnt_dec = cnt_r - CW'(1);

  // Pick the largest of the sifted value and the present children.
  always_comb begin
    best_v      = val_r;
    best_i      = XW'(pos_r);
    best_is_pos = 1'b1;
    if (lv_r > best_v) begin
      best_v      = lv_r;
      best_i      = lc;
      best_is_pos = 1'b0;
    end
    if (rvld_r && rdata_r > best_v) begin
      best_v      = rdata_r;
      best_i      = rc;
      best_is_pos = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    both_nxt      = both_r;
    idx_nxt       = idx_r;
    rdv_nxt       = 1'b0;
    chk_nxt       = chk_r;
    lv_nxt        = lv_r;
    rvld_nxt      = rvld_r;
    stat_nxt      = stat_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    nk_nxt        = nk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    re            = 1'b0;
    ra            = '0;
    we            = 1'b0;
    wa            = pos_r;
    wd            = val_r;
    in_stall      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_nxt  = in_data.cmd;
          key_nxt  = in_data.key;
          nk_nxt   = in_data.new_key;
          stat_nxt = STAT_OK;
          idx_nxt  = '0;
          both_nxt = 1'b0;
          state_nxt = ST_FIN;
          case (in_data.cmd)
            CMD_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                stat_nxt = STAT_FULL;
              end else begin
                pos_nxt   = cnt_r[AW-1:0];
                val_nxt   = in_data.key;
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = ST_UP_RD;
              end
            end
            CMD_POP: begin
              if (cnt_r == '0) begin
                stat_nxt = STAT_EMPTY;
              end else begin
                cnt_nxt  = cnt_dec;
                pos_nxt  = '0;
                both_nxt = 1'b1;
                if (cnt_dec != '0) state_nxt = ST_LAST_RD;
              end
            end
            CMD_REPLACE, CMD_DELETE: state_nxt = ST_SRCH;
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      // Scan with one read in flight; compare the previous beat's data.
      ST_SRCH: begin
        if (rdv_r && rdata_r == key_r) begin
          pos_nxt = chk_r;
          if (cmd_r == CMD_REPLACE) begin
            val_nxt  = nk_r;
            both_nxt = 1'b0;
            if (nk_r > key_r)      state_nxt = ST_UP_RD;
            else if (nk_r < key_r) state_nxt = ST_DN_L;
            else                   state_nxt = ST_FIN;
          end else begin
            cnt_nxt  = cnt_dec;
            both_nxt = 1'b1;
            if (CW'(chk_r) < cnt_dec) state_nxt = ST_LAST_RD;
            else                      state_nxt = ST_FIN;
          end
        end else if (idx_r < cnt_r) begin
          re      = 1'b1;
          ra      = idx_r[AW-1:0];
          rdv_nxt = 1'b1;
          chk_nxt = idx_r[AW-1:0];
          idx_nxt = idx_r + CW'(1);
        end else if (!rdv_r) begin
          stat_nxt  = STAT_MISSING;
          state_nxt = ST_FIN;
        end
      end

      ST_LAST_RD: begin
        re        = 1'b1;
        ra        = cnt_r[AW-1:0];
        state_nxt = ST_LAST_GET;
      end

      ST_LAST_GET: begin
        val_nxt   = rdata_r;
        state_nxt = ST_UP_RD;
      end

      ST_UP_RD: begin
        if (pos_r == '0) begin
          if (both_r) begin
            state_nxt = ST_DN_L;
          end else begin
            we        = 1'b1;
            state_nxt = ST_FIN;
          end
        end else begin
          re        = 1'b1;
          ra        = parent;
          state_nxt = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        if (val_r > rdata_r) begin
          we        = 1'b1;
          wd        = rdata_r;
          pos_nxt   = parent;
          both_nxt  = 1'b0;
          state_nxt = ST_UP_RD;
        end else if (both_r) begin
          state_nxt = ST_DN_L;
        end else begin
          we        = 1'b1;
          state_nxt = ST_FIN;
        end
      end

      ST_DN_L: begin
        if (lc >= cnt_x) begin
          we        = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          re        = 1'b1;
          ra        = lc[AW-1:0];
          state_nxt = ST_DN_R;
        end
      end

      ST_DN_R: begin
        lv_nxt   = rdata_r;
        rvld_nxt = rc < cnt_x;
        if (rc < cnt_x) begin
          re = 1'b1;
          ra = rc[AW-1:0];
        end
        state_nxt = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        we = 1'b1;
        if (best_is_pos) begin
          state_nxt = ST_FIN;
        end else begin
          wd        = best_v;
          pos_nxt   = best_i[AW-1:0];
          state_nxt = ST_DN_L;
        end
      end

      ST_FIN: begin
        re        = 1'b1;
        ra        = '0;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = stat_r;
          out_data_nxt.top_value   = (cnt_r == '0) ? INT_MIN : rdata_r;
          out_data_nxt.entry_count = 7'(cnt_r);
          state_nxt                = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/mhpq_chk.sv
// Port-level checker for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue_assert.svh.
`include "max_heap_priority_queue_assert.svh"

module mhpq_chk #(
  parameter int CAPACITY = 64
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input mhpq_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input mhpq_pkg::out_t out_data
);
  import mhpq_pkg::*;

  `MHPQ_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_data))
  `MHPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `MHPQ_ASSERT_IMPLY(a_count_max, clk, rst_n, out_valid, out_data.entry_count <= 7'(CAPACITY))
  `MHPQ_ASSERT_IMPLY(a_empty_pop, clk, rst_n, out_valid && out_data.status == STAT_EMPTY, out_data.entry_count == '0)
  `MHPQ_ASSERT_IMPLY(a_empty_top, clk, rst_n, out_valid && out_data.entry_count == '0, out_data.top_value == INT_MIN)

endmodule

bind max_heap_priority_queue mhpq_chk #(.CAPACITY(CAPACITY)) u_mhpq_chk (.*);

>>> bench/tb_max_heap_priority_queue.sv
// Self-checking bench for the max-heap priority queue: drives command beats,
// predicts status, maximum and count with a local heap, checks every result.
// Depends on mhpq_pkg and max_heap_priority_queue.
module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #10 clk = ~clk;

  max_heap_priority_queue #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // local heap mirror
  logic signed [31:0] heap_keys [CAP];
  int fill_level = 0;

  in_t cmd_queue [$];
  out_t expected_results [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int phase = 0;          // 0: receiver slow, 1: sender slow, 2: no idling
  int hold_cycles = 0;
  bit stimulus_done = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic void swap_keys(input int a, input int b);
    logic signed [31:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void climb(input int p);
    int up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (heap_keys[p] <= heap_keys[up]) break;
      swap_keys(p, up);
      p = up;
    end
  endfunction

  function automatic void descend(input int p);
    int best;
    while (p < fill_level) begin
      best = p;
      if (2*p+1 < fill_level && heap_keys[2*p+1] > heap_keys[best]) best = 2*p+1;
      if (2*p+2 < fill_level && heap_keys[2*p+2] > heap_keys[best]) best = 2*p+2;
      if (best == p) break;
      swap_keys(p, best);
      p = best;
    end
  endfunction

  function automatic int find_slot(input logic signed [31:0] k);
    for (int i = 0; i < fill_level; i++)
      if (heap_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic out_t apply_command(input in_t c);
    out_t r;
    int pos;
    r.status = STAT_OK;
    case (c.cmd)
      CMD_INSERT: begin
        if (fill_level >= CAP) r.status = STAT_FULL;
        else begin
          heap_keys[fill_level] = c.key;
          fill_level++;
          climb(fill_level - 1);
        end
      end
      CMD_POP: begin
        if (fill_level == 0) r.status = STAT_EMPTY;
        else begin
          fill_level--;
          heap_keys[0] = heap_keys[fill_level];
          descend(0);
        end
      end
      CMD_REPLACE: begin
        pos = find_slot(c.key);
        if (pos < 0) r.status = STAT_MISSING;
        else begin
          heap_keys[pos] = c.new_key;
          if (c.new_key > c.key) climb(pos);
          else if (c.new_key < c.key) descend(pos);
        end
      end
      CMD_DELETE: begin
        pos = find_slot(c.key);
        if (pos < 0) r.status = STAT_MISSING;
        else begin
          fill_level--;
          if (pos < fill_level) begin
            heap_keys[pos] = heap_keys[fill_level];
            climb(pos);
            descend(pos);
          end
        end
      end
      default: ;
    endcase
    r.top_value = (fill_level == 0) ? INT_MIN : heap_keys[0];
    r.entry_count = fill_level[6:0];
    return r;
  endfunction

  // pick a key mostly from a small pool so that searches hit
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return INT_MIN;
      2: return 32'sh7fff_ffff;
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic in_t make_cmd(input logic [2:0] op, input logic signed [31:0] k,
                                   input logic signed [31:0] nk);
    in_t c;
    c.cmd = op;
    c.key = k;
    c.new_key = nk;
    return c;
  endfunction

  initial begin
    logic [2:0] op;
    int sel;
    // directed: empty cases, extremes, unused codes
    cmd_queue.push_back(make_cmd(CMD_PEEK, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_POP, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_REPLACE, 5, 6));
    cmd_queue.push_back(make_cmd(CMD_DELETE, 5, 0));
    cmd_queue.push_back(make_cmd(CMD_INSERT, INT_MIN, 0));
    cmd_queue.push_back(make_cmd(CMD_INSERT, 32'sh7fff_ffff, 0));
    cmd_queue.push_back(make_cmd(CMD_INSERT, 32'sh5555_5555, 0));
    cmd_queue.push_back(make_cmd(CMD_INSERT, -32'sh5555_5556, 0));
    cmd_queue.push_back(make_cmd(CMD_REPLACE, 32'sh5555_5555, 32'sh5555_5555));
    cmd_queue.push_back(make_cmd(CMD_REPLACE, 32'sh7fff_ffff, INT_MIN));
    cmd_queue.push_back(make_cmd(CMD_REPLACE, INT_MIN, 32'sh7fff_ffff));
    cmd_queue.push_back(make_cmd(3'd5, -1, -1));
    cmd_queue.push_back(make_cmd(3'd6, 0, 0));
    cmd_queue.push_back(make_cmd(3'd7, -1, 32'sh2aaa_aaaa));
    cmd_queue.push_back(make_cmd(CMD_DELETE, 32'sh7fff_ffff, 0));
    cmd_queue.push_back(make_cmd(CMD_DELETE, 12345, 0));
    cmd_queue.push_back(make_cmd(CMD_POP, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_POP, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_POP, 0, 0));
    // fill past capacity to hit the full status
    for (int i = 0; i < CAP + 2; i++)
      cmd_queue.push_back(make_cmd(CMD_INSERT, $urandom_range(0, 30), 0));
    // random: weighted toward inserts, with a drain of pops now and then
    for (int i = 0; i < 1950; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) op = CMD_INSERT;
      else if (sel < 60) op = CMD_POP;
      else if (sel < 75) op = CMD_REPLACE;
      else if (sel < 90) op = CMD_DELETE;
      else op = 3'($urandom_range(0, 7));
      if (i % 400 > 300) op = CMD_POP;   // drain now and then
      cmd_queue.push_back(make_cmd(op, pick_key(), pick_key()));
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_command(in_data));
        void'(cmd_queue.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (cmd_queue.size() > ((in_valid && !in_stall) ? 0 : 0) &&
            !(in_valid && !in_stall && cmd_queue.size() == 0) &&
            !(phase == 0 && $urandom_range(0, 99) < 29) &&
            !(phase == 1 && $urandom_range(0, 99) < 69)) begin
          in_valid <= 1'b1;
          in_data <= cmd_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (cmd_queue.size() < 1300 && phase == 0) phase <= 1;
      if (cmd_queue.size() < 650 && phase == 1) phase <= 2;
      if (cmd_queue.size() == 0) stimulus_done <= 1'b1;
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (cycle_count == 3000) begin
      hold_cycles <= 2000;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (phase == 0) ? ($urandom_range(0, 99) < 69) :
                   (phase == 1) ? ($urandom_range(0, 99) < 29) : 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", out_data.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) report("status", out_data.status, want.status);
        if (out_data.top_value !== want.top_value)
          report("top_value", out_data.top_value, want.top_value);
        if (out_data.entry_count !== want.entry_count)
          report("entry_count", out_data.entry_count, want.entry_count);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (stimulus_done && !in_valid && expected_results.size() == 0 || cycle_count >= CYCLE_LIMIT);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
    end else begin
      repeat (200) @(posedge clk);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
    end
    $finish;
  end

endmodule
